// ----- hdl/gcsl_pkg.sv -----
// ----------------------------------------------------------------------------
// gcsl_pkg
// shared types, widths and codes of the graph closure and component lister
// ----------------------------------------------------------------------------
package gcsl_pkg;

  localparam int NODES = 16;
  localparam int IDX_W = $clog2(NODES);
  localparam int CNT_W = IDX_W + 1;

  typedef logic [NODES-1:0] row_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LIST   = 2'd2
  } action_e;

  typedef struct packed {
    logic wr;
    logic rm;
    idx_t src;
    idx_t dst;
    logic set;
  } adj_cmd_t;

  typedef struct packed {
    logic valid;
    row_t mask;
    logic last;
  } push_t;

  function automatic row_t keep_mask(cnt_t n);
    row_t keep;
    for (int j = 0; j < NODES; j++) begin
      keep[j] = (CNT_W'(j) < n);
    end
    return keep;
  endfunction

endpackage

// ----- hdl/graph_closure_scc_lister.sv -----
// ----------------------------------------------------------------------------
// graph_closure_scc_lister
// directed graph store with reachability closure and cyclic component listing
// edge writes and node removals are registered into the adjacency matrix; input stays ready
// listing: copy of all 16 rows, per node k a row load and a relax sweep of the
//   n active rows (single row-or unit), n-node scan, flush; plus output stalls
// one output register carries one beat per component, or one zero beat if none
// reset clears adjacency, closure and node_count; ready right after reset
// ----------------------------------------------------------------------------
module graph_closure_scc_lister (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,    // node_count
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // action[1:0], from_node[5:2], to_node[9:6],
                                     // edge_present[10], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // member_mask[15:0]
  output logic        m_axis_tlast   // last_component
);
  import gcsl_pkg::*;

  cnt_t     node_count_q;
  cnt_t     n_eff;
  logic     in_beat;
  logic [1:0] action;
  idx_t     from_node;
  idx_t     to_node;
  logic     edge_present;
  logic     src_ok;
  logic     dst_ok;
  adj_cmd_t cmd;
  logic     start;
  row_t     adj_row;
  idx_t     adj_raddr;
  push_t    push;
  logic     busy;
  logic     out_free;
  logic     out_valid_q;
  row_t     out_mask_q;
  logic     out_last_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= '0;
    end else if (cfg_valid_i) begin
      node_count_q <= cfg_data_i;
    end
  end

  assign n_eff = (node_count_q > CNT_W'(NODES)) ? CNT_W'(NODES) : node_count_q;

  assign s_axis_tready = !busy;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign action        = s_axis_tdata[1:0];
  assign from_node     = s_axis_tdata[5:2];
  assign to_node       = s_axis_tdata[9:6];
  assign edge_present  = s_axis_tdata[10];
  assign src_ok        = ({1'b0, from_node} < n_eff);
  assign dst_ok        = ({1'b0, to_node} < n_eff);

  always_comb begin
    cmd     = '{wr: 1'b0, rm: 1'b0, src: from_node, dst: to_node, set: edge_present};
    start   = 1'b0;
    if (in_beat) begin
      unique case (action)
        ACT_WRITE:  cmd.wr = src_ok && dst_ok;
        ACT_REMOVE: cmd.rm = src_ok;
        ACT_LIST:   start  = 1'b1;
        default:    ;
      endcase
    end
  end

  gcsl_adj u_adj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .raddr_i (adj_raddr),
    .rdata_o (adj_row)
  );

  gcsl_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .n_i         (n_eff),
    .adj_row_i   (adj_row),
    .adj_raddr_o (adj_raddr),
    .out_free_i  (out_free),
    .push_o      (push),
    .busy_o      (busy)
  );

  // output register
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push.valid) begin
      out_mask_q <= push.mask;
      out_last_q <= push.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_mask_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ----- hdl/gcsl_adj.sv -----
// ----------------------------------------------------------------------------
// gcsl_adj
// adjacency bit matrix: edge set/clear, node removal and one row read port
// ----------------------------------------------------------------------------
module gcsl_adj (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gcsl_pkg::adj_cmd_t cmd_i,
  input  gcsl_pkg::idx_t    raddr_i,
  output gcsl_pkg::row_t    rdata_o
);
  import gcsl_pkg::*;

  row_t adj_q [NODES];
  row_t adj_d [NODES];

  always_comb begin
    adj_d = adj_q;
    if (cmd_i.wr) begin
      adj_d[cmd_i.src][cmd_i.dst] = cmd_i.set;
    end
    if (cmd_i.rm) begin
      for (int j = 0; j < NODES; j++) begin
        adj_d[j][cmd_i.src] = 1'b0;
      end
      adj_d[cmd_i.src] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NODES; j++) begin
        adj_q[j] <= '0;
      end
    end else begin
      adj_q <= adj_d;
    end
  end

  assign rdata_o = adj_q[raddr_i];

endmodule

// ----- hdl/gcsl_engine.sv -----
// ----------------------------------------------------------------------------
// gcsl_engine
// closure sequencer: copies the adjacency rows, then one shared row-or unit over
// the closure rows, then a scan that picks out each cyclic component
// ----------------------------------------------------------------------------
module gcsl_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  gcsl_pkg::cnt_t   n_i,
  input  gcsl_pkg::row_t   adj_row_i,
  output gcsl_pkg::idx_t   adj_raddr_o,
  input  logic             out_free_i,
  output gcsl_pkg::push_t  push_o,
  output logic             busy_o
);
  import gcsl_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_INIT  = 6'b000010,
    ST_LOADK = 6'b000100,
    ST_RELAX = 6'b001000,
    ST_SCAN  = 6'b010000,
    ST_FLUSH = 6'b100000
  } state_e;

  state_e state_q, state_d;
  idx_t   i_q, i_d;
  idx_t   k_q, k_d;
  row_t   rowk_q, rowk_d;
  row_t   taken_q, taken_d;
  row_t   pend_q, pend_d;
  logic   have_q, have_d;
  row_t   closure_q [NODES];
  row_t   closure_d [NODES];

  idx_t   rd_addr;
  row_t   rd_row;
  row_t   col;
  row_t   keep;
  row_t   members;
  logic   hit;
  logic   last_i;
  logic   last_k;
  push_t  push;

  assign keep    = keep_mask(n_i);
  assign rd_addr = (state_q == ST_LOADK) ? k_q : i_q;
  assign rd_row  = closure_q[rd_addr];
  assign last_i  = ({1'b0, i_q} == n_i - CNT_W'(1));
  assign last_k  = ({1'b0, k_q} == n_i - CNT_W'(1));
  assign hit     = rd_row[i_q] && !taken_q[i_q];
  assign members = rd_row & col;

  // column i of the closure: nodes that reach node i
  always_comb begin
    for (int j = 0; j < NODES; j++) begin
      col[j] = closure_q[j][i_q];
    end
  end

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    k_d       = k_q;
    rowk_d    = rowk_q;
    taken_d   = taken_q;
    pend_d    = pend_q;
    have_d    = have_q;
    closure_d = closure_q;
    push      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_INIT;
          i_d     = '0;
          taken_d = '0;
          pend_d  = '0;
          have_d  = 1'b0;
        end
      end
      ST_INIT: begin
        closure_d[i_q] = ({1'b0, i_q} < n_i) ? (adj_row_i & keep) : '0;
        if (i_q == IDX_W'(NODES - 1)) begin
          i_d     = '0;
          k_d     = '0;
          state_d = (n_i == '0) ? ST_FLUSH : ST_LOADK;
        end else begin
          i_d = i_q + IDX_W'(1);
        end
      end
      ST_LOADK: begin
        rowk_d  = rd_row;
        i_d     = '0;
        state_d = ST_RELAX;
      end
      ST_RELAX: begin
        if (rd_row[k_q]) begin
          closure_d[i_q] = rd_row | rowk_q;
        end
        if (last_i) begin
          i_d = '0;
          if (last_k) begin
            state_d = ST_SCAN;
          end else begin
            k_d     = k_q + IDX_W'(1);
            state_d = ST_LOADK;
          end
        end else begin
          i_d = i_q + IDX_W'(1);
        end
      end
      ST_SCAN: begin
        if (!(hit && have_q && !out_free_i)) begin
          if (hit) begin
            if (have_q) begin
              push = '{valid: 1'b1, mask: pend_q, last: 1'b0};
            end
            pend_d  = members;
            have_d  = 1'b1;
            taken_d = taken_q | members;
          end
          if (last_i) begin
            state_d = ST_FLUSH;
          end else begin
            i_d = i_q + IDX_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (out_free_i) begin
          push    = '{valid: 1'b1, mask: pend_q, last: 1'b1};
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      k_q     <= '0;
      taken_q <= '0;
      have_q  <= 1'b0;
      for (int j = 0; j < NODES; j++) begin
        closure_q[j] <= '0;
      end
    end else begin
      state_q   <= state_d;
      i_q       <= i_d;
      k_q       <= k_d;
      taken_q   <= taken_d;
      have_q    <= have_d;
      closure_q <= closure_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rowk_q <= rowk_d;
    pend_q <= pend_d;
  end

  assign adj_raddr_o = i_q;
  assign push_o      = push;
  assign busy_o      = (state_q != ST_IDLE);

`ifndef SYNTHESIS
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> out_free_i)
    else $error("result pushed while output register is full");

  a_start_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && start_i) |=> (state_q == ST_INIT))
    else $error("listing start did not enter the copy sweep");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.valid && push.last) |=> (state_q == ST_IDLE))
    else $error("final result did not end the listing");

  a_taken_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> ((taken_q & ~keep) == '0))
    else $error("component holds a node outside the active range");
`endif

endmodule

// ----- sim/graph_closure_scc_lister_chk.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// graph_closure_scc_lister_chk
// watches the config, input and output channels of the component lister,
// keeps its own copy of the graph, predicts the component beats of every
// listing and compares each output beat with the oldest prediction
// ----------------------------------------------------------------------------
module graph_closure_scc_lister_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [15:0] s_tdata_i,    // action[1:0], from_node[5:2], to_node[9:6],
                                    // edge_present[10], zero pad
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,    // member_mask[15:0]
  input  logic        m_tlast_i,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          list_cnt_o,
  output int          comp_cnt_o
);
  import gcsl_pkg::*;

  localparam int MAX_COMPS = 16;

  typedef struct packed {
    row_t members;
    logic is_last;
  } comp_beat_t;

  row_t       graph_q [NODES];
  logic [4:0] node_count_q;
  comp_beat_t comp_fifo [$];
  comp_beat_t exp_beat;

  function automatic int active_nodes();
    return (int'(node_count_q) > NODES) ? NODES : int'(node_count_q);
  endfunction

  function automatic void predict_listing(int n);
    row_t       reach [NODES];
    row_t       keep;
    row_t       taken;
    row_t       members;
    comp_beat_t entry;
    int         found;
    keep = '0;
    for (int j = 0; j < n; j++) keep[j] = 1'b1;
    for (int i = 0; i < NODES; i++) reach[i] = (i < n) ? (graph_q[i] & keep) : '0;
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < n; i++) begin
        if (reach[i][k]) reach[i] |= reach[k];
      end
    end
    taken = '0;
    found = 0;
    for (int i = 0; i < n; i++) begin
      if (found < MAX_COMPS && reach[i][i] && !taken[i]) begin
        members = '0;
        for (int j = 0; j < n; j++) begin
          if (reach[i][j] && reach[j][i]) members[j] = 1'b1;
        end
        taken |= members;
        entry.members = members;
        entry.is_last = 1'b0;
        comp_fifo.insert(comp_fifo.size(), entry);
        found++;
      end
    end
    if (found == 0) begin
      entry.members = '0;
      entry.is_last = 1'b1;
      comp_fifo.insert(comp_fifo.size(), entry);
    end else begin
      comp_fifo[comp_fifo.size()-1].is_last = 1'b1;
    end
  endfunction

  function automatic void apply_beat(logic [15:0] beat);
    logic [1:0] act;
    idx_t       src;
    idx_t       dst;
    logic       present;
    int         n;
    act     = beat[1:0];
    src     = beat[5:2];
    dst     = beat[9:6];
    present = beat[10];
    n       = active_nodes();
    case (act)
      ACT_WRITE: begin
        if (int'(src) < n && int'(dst) < n) graph_q[src][dst] = present;
      end
      ACT_REMOVE: begin
        if (int'(src) < n) begin
          graph_q[src] = '0;
          for (int j = 0; j < NODES; j++) graph_q[j][src] = 1'b0;
        end
      end
      ACT_LIST: begin
        predict_listing(n);
        list_cnt_o++;
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) graph_q[i] = '0;
      node_count_q = '0;
      comp_fifo.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
      list_cnt_o = 0;
      comp_cnt_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        comp_cnt_o++;
        if (comp_fifo.size() == 0) begin
          fail_cnt_o++;
          $display("%0t: unexpected component beat, expected none, got mask %h last %b",
                   $time, m_tdata_i, m_tlast_i);
        end else begin
          exp_beat = comp_fifo.pop_front();
          if (m_tdata_i !== exp_beat.members) begin
            fail_cnt_o++;
            $display("%0t: member_mask mismatch, expected %h, got %h",
                     $time, exp_beat.members, m_tdata_i);
          end
          if (m_tlast_i !== exp_beat.is_last) begin
            fail_cnt_o++;
            $display("%0t: last_component mismatch, expected %b, got %b",
                     $time, exp_beat.is_last, m_tlast_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) node_count_q = cfg_data_i;
      if (s_tvalid_i && s_tready_i) apply_beat(s_tdata_i);
      pending_o = comp_fifo.size();
    end
  end

endmodule

// ----- sim/graph_closure_scc_lister_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// graph_closure_scc_lister_tb
// drives edge writes, node removals and listings into the component lister
// under several node counts and idle patterns; the checker beside the block
// predicts and compares every component beat
// ----------------------------------------------------------------------------
module graph_closure_scc_lister_tb;
  import gcsl_pkg::*;

  localparam int         WATCHDOG_LIMIT = 5000;
  localparam int         SETTLE_CYCLES  = 16;
  localparam logic [1:0] ACT_UNUSED     = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  int fail_cnt;
  int pending_cnt;
  int list_cnt;
  int comp_cnt;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int cur_nodes      = 0;
  int useful_items   = 0;
  int sent_items     = 0;
  int cfg_writes     = 0;
  int quiet_cycles   = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  graph_closure_scc_lister u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  graph_closure_scc_lister_chk u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tlast_i   (m_axis_tlast),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending_cnt),
    .list_cnt_o  (list_cnt),
    .comp_cnt_o  (comp_cnt)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no beat for %0d cycles, %0d component beats outstanding",
               $time, WATCHDOG_LIMIT, pending_cnt);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [3:0] pick_node();
    if (cur_nodes > 0 && $urandom_range(99) < 90) return 4'($urandom_range(cur_nodes - 1));
    return 4'($urandom_range(15));
  endfunction

  task automatic send_item(input logic [1:0] act, input logic [3:0] from_node,
                           input logic [3:0] to_node, input logic present);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, present, to_node, from_node, act};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_items++;
    if (act == ACT_LIST ||
        (act == ACT_WRITE && from_node < cur_nodes && to_node < cur_nodes) ||
        (act == ACT_REMOVE && from_node < cur_nodes)) useful_items++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_node_count(input logic [4:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_nodes = (int'(value) > NODES) ? NODES : int'(value);
    cfg_writes++;
  endtask

  task automatic run_random(input int target);
    int         goal;
    int         roll;
    int         ring_len;
    logic [3:0] first_node;
    logic [3:0] prev_node;
    logic [3:0] next_node;
    goal = sent_items + target;
    while (sent_items < goal) begin
      roll = $urandom_range(99);
      if (roll < 15) begin
        send_item(2'($urandom_range(3)), 4'($urandom_range(15)), 4'($urandom_range(15)),
                  1'($urandom_range(1)));
      end else if (roll < 27) begin
        // prune a few nodes, then list what is left
        repeat ($urandom_range(1, 4))
          send_item(ACT_REMOVE, pick_node(), 4'($urandom_range(15)), 1'($urandom_range(1)));
        send_item(ACT_LIST, 4'($urandom_range(15)), 4'($urandom_range(15)),
                  1'($urandom_range(1)));
      end else if (roll < 37) begin
        // many self loops, many small components
        repeat ($urandom_range(2, 16)) begin
          next_node = pick_node();
          send_item(ACT_WRITE, next_node, next_node, 1'b1);
        end
        send_item(ACT_LIST, 4'($urandom_range(15)), 4'($urandom_range(15)),
                  1'($urandom_range(1)));
      end else begin
        // ring through random nodes plus a few stray edges
        ring_len   = $urandom_range(1, 5);
        first_node = pick_node();
        prev_node  = first_node;
        for (int i = 1; i < ring_len; i++) begin
          next_node = pick_node();
          send_item(ACT_WRITE, prev_node, next_node, 1'b1);
          prev_node = next_node;
        end
        send_item(ACT_WRITE, prev_node, first_node, 1'b1);
        repeat ($urandom_range(0, 3))
          send_item(ACT_WRITE, pick_node(), pick_node(), ($urandom_range(99) < 70));
        send_item(ACT_LIST, 4'($urandom_range(15)), 4'($urandom_range(15)),
                  1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    src_idle_pct   = 20;
    sink_stall_pct = 74;

    // empty graph, full set of self loops, merge of two loops
    write_node_count(5'd16);
    send_item(ACT_LIST, 4'd0, 4'd0, 1'b0);
    for (int i = 0; i < NODES; i++) send_item(ACT_WRITE, 4'(i), 4'(i), 1'b1);
    send_item(ACT_LIST, 4'hf, 4'hf, 1'b1);
    send_item(ACT_UNUSED, 4'($urandom_range(15)), 4'($urandom_range(15)), 1'b1);
    send_item(ACT_REMOVE, 4'd15, 4'd0, 1'b0);
    send_item(ACT_WRITE, 4'd0, 4'd0, 1'b0);
    send_item(ACT_WRITE, 4'd3, 4'd9, 1'b1);
    send_item(ACT_WRITE, 4'd9, 4'd3, 1'b1);
    send_item(ACT_LIST, 4'd0, 4'd0, 1'b0);

    // shrunk node count, out of range writes and removal
    write_node_count(5'd4);
    send_item(ACT_WRITE, 4'd15, 4'd0, 1'b1);
    send_item(ACT_WRITE, 4'd0, 4'd15, 1'b1);
    send_item(ACT_REMOVE, 4'd10, 4'd0, 1'b0);
    send_item(ACT_LIST, 4'd0, 4'd0, 1'b0);

    write_node_count(5'd31);
    run_random(40);
    write_node_count(5'd5);
    run_random(30);

    src_idle_pct   = 74;
    sink_stall_pct = 20;
    write_node_count(5'd0);
    run_random(8);
    write_node_count(5'd12);
    run_random(35);
    write_node_count(5'd2);
    run_random(25);

    src_idle_pct   = 0;
    sink_stall_pct = 0;
    write_node_count(5'd16);
    run_random(40);
    write_node_count(5'd1);
    run_random(12);
    write_node_count(5'd9);
    run_random(25);

    drain();
    $display("covered %0d input beats, %0d effective, with %0d listings under %0d node counts",
             sent_items, useful_items, list_cnt, cfg_writes);
    $display("checked %0d component beats, %0d mismatches", comp_cnt, fail_cnt);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/gcsl_pkg.sv
hdl/gcsl_adj.sv
hdl/gcsl_engine.sv
hdl/graph_closure_scc_lister.sv
sim/graph_closure_scc_lister_chk.sv
sim/graph_closure_scc_lister_tb.sv
